>>> rtl/core/rd_pkg.sv
// Package for the restoring divider: widths, the per-stage payload type
// and the single restoring step. No dependencies.
`timescale 1ns / 1ps

package rd_pkg;

    localparam int WIDTH = 16;
    localparam int DIV_W = WIDTH - 1;

    typedef struct packed {
        logic [WIDTH-1:0] acc;
        logic [WIDTH-1:0] quo;
        logic [DIV_W-1:0] div;
    } stage_t;

    // One restoring iteration: shift, trial subtract, restore on a negative result.
    function automatic stage_t div_step(input stage_t s);
        logic [WIDTH-1:0] acc_sh;
        logic [WIDTH-1:0] diff;
        stage_t           r;
        acc_sh = {s.acc[WIDTH-2:0], s.quo[WIDTH-1]};
        diff   = acc_sh - {1'b0, s.div};
        r.div  = s.div;
        if (diff[WIDTH-1])
        begin
            r.acc = acc_sh;
            r.quo = {s.quo[WIDTH-2:0], 1'b0};
        end
        else
        begin
            r.acc = diff;
            r.quo = {s.quo[WIDTH-2:0], 1'b1};
        end
        return r;
    endfunction

endpackage

>>> rtl/core/rd_stage.sv
// One pipeline stage of the restoring divider: a single iteration plus its
// payload and valid register. Depends on rd_pkg.
`timescale 1ns / 1ps

module rd_stage
    import rd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   up_valid,
    output logic   up_ready,
    input  stage_t up_data,
    output logic   dn_valid,
    input  logic   dn_ready,
    output stage_t dn_data
);

    logic   valid_reg;
    logic   valid_next;
    stage_t data_reg;

    // Take a new beat when empty or when the held beat leaves this cycle.
    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= div_step(up_data);
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

>>> rtl/core/restoring_divider.sv
// Top level of the pipelined unsigned restoring divider.
// Depends on rd_pkg and rd_stage.
`timescale 1ns / 1ps

// Usage
//   Input channel (div_valid / div_ready) carries one beat: dividend and
//   divisor. The divisor is WIDTH-1 bits, so its datapath top bit is zero.
//   Output channel (res_valid / res_ready) carries quotient and remainder.
//   Each of the WIDTH iterations has its own register stage. A beat accepted
//   at the input passes through the stage registers in order before it
//   shows up on res_valid, and it can then leave when res_ready is high.
//   Throughput: one beat per cycle while res_ready stays high; the chain of
//   WIDTH stages sets latency, a single stage sets the rate.
//   Each stage holds its own valid bit; a stage loads whenever it is empty
//   or its occupant moves on, so bubbles collapse and the input keeps
//   taking beats while a finished result waits at the output.
//   When the receiver stalls, the last stage holds its result, and stages
//   behind it fill up one by one; div_ready drops only once the first
//   stage is full and cannot advance. Nothing is dropped or repeated.
//   A zero divisor runs the same iteration; the remainder then equals the
//   dividend.
//   Reset clears all valid bits at once; payload registers are not reset.
//   Nothing is kept between beats.

module restoring_divider
    import rd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             div_valid,
    output logic             div_ready,
    input  logic [WIDTH-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             res_valid,
    input  logic             res_ready,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    logic   vld [WIDTH+1];
    logic   rdy [WIDTH+1];
    stage_t data [WIDTH+1];

    // Seed the first stage: accumulator cleared, quotient holds the dividend.
    assign vld[0]       = div_valid;
    assign div_ready    = rdy[0];
    assign data[0].acc  = '0;
    assign data[0].quo  = dividend;
    assign data[0].div  = divisor;

    // One stage per iteration; ready ripples back from the output.
    genvar gi;
    generate
        for (gi = 0; gi < WIDTH; gi++)
        begin : g_stage
            rd_stage u_stage (
                .clk      (clk),
                .rst_n    (rst_n),
                .up_valid (vld[gi]),
                .up_ready (rdy[gi]),
                .up_data  (data[gi]),
                .dn_valid (vld[gi+1]),
                .dn_ready (rdy[gi+1]),
                .dn_data  (data[gi+1])
            );
        end
    endgenerate

    // Drive the output beat straight from the last stage.
    assign res_valid   = vld[WIDTH];
    assign rdy[WIDTH]  = res_ready;
    assign quotient    = data[WIDTH].quo;
    assign remainder   = data[WIDTH].acc;

    // A nonzero divisor always leaves a remainder below it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && data[WIDTH].div != '0) |-> (remainder < {1'b0, data[WIDTH].div}))
        else $error("remainder not below divisor");

    // Input back-pressure only when the first stage is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        !div_ready |-> vld[1])
        else $error("input stalled with empty first stage");

    // An accepted input beat lands in the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (div_valid && div_ready) |=> vld[1])
        else $error("accepted beat lost at first stage");

    // A stalled result stays put in the last stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(data[WIDTH])))
        else $error("stalled result changed");

endmodule
